// ----- rtl/sfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace block
// Payload structs, register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // default sizes of the pattern window and the replacement string
   localparam int MAX_PATTERN_DEF     = 8;
   localparam int MAX_REPLACEMENT_DEF = 8;

   // fixed field widths
   localparam int BYTE_W    = 8;
   localparam int CFG_W     = 64;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 3;

   // register indexes
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_SEARCH_BYTES  = 3'd0;
   localparam csr_index_type CSR_SEARCH_LEN    = 3'd1;
   localparam csr_index_type CSR_REPLACE_BYTES = 3'd2;
   localparam csr_index_type CSR_REPLACE_LEN   = 3'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_end;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_present;
      logic              out_stream_end;
      logic              out_run_last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT
   } sfr_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // take the input item into the window
      logic eval;   // resolve match and emit plan
      logic emit;   // produce one result into the output register
   } sfr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_output;  // the item under evaluation yields at least one result
      logic emit_last;   // the next result is the last of this item
      logic out_free;    // the output register can take a result this cycle
   } sfr_status_type;

endpackage
`default_nettype wire

// ----- rtl/sfr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_ctrl: sequencing state machine
// Accepts one item, lets the datapath evaluate it, then steps the datapath
// through the results of that item as the output register frees up.
// ----------------------------------------------------------------------------
module sfr_ctrl
   import sfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire sfr_status_type status,
   output sfr_cmd_type         cmd
);

   sfr_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = status.has_output ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // a stalled output keeps the sequencer in the emit state
   a_emit_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !status.out_free) |=> state_ff == ST_EMIT)
      else $error("sequencer left emit state while output was stalled");
`endif

endmodule
`default_nettype wire

// ----- rtl/sfr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_datapath: window, pattern compare and output register
// Holds the configuration, the window of held bytes plus the new byte, the
// prefix compare at each start offset, and the result register.
// ----------------------------------------------------------------------------
module sfr_datapath
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire req_payload_type   req_data,
   input  wire logic              csr_valid,
   input  wire csr_index_type     csr_index,
   input  wire logic [CFG_W-1:0]  csr_wdata,
   input  wire sfr_cmd_type       cmd,
   output sfr_status_type         status,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_payload_type        rsp_data
);

   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int RW = $clog2(MAX_REPLACEMENT + 2);
   localparam int EW = (CW > RW) ? CW : RW;

   // configuration
   logic [CFG_W-1:0] search_bytes_ff,  search_bytes_in;
   logic [LEN_W-1:0] search_len_ff,    search_len_in;
   logic [CFG_W-1:0] replace_bytes_ff, replace_bytes_in;
   logic [LEN_W-1:0] replace_len_ff,   replace_len_in;

   // window and emit control
   logic [BYTE_W-1:0] win_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] win_in [MAX_PATTERN];
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              end_ff, end_in;
   logic              repl_ff, repl_in;
   logic              marker_ff, marker_in;
   logic [EW-1:0]     rem_ff, rem_in;
   logic [RW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0]  slen_eff;
   logic [LEN_W-1:0]  rlen_eff;
   logic [MAX_PATTERN-1:0] pre;
   logic [MAX_PATTERN-1:0] ok;
   logic [CW-1:0]     start;
   logic [CW-1:0]     win_emit;
   logic              match;
   logic              emit_last;
   logic [CFG_W-1:0]  rep_shift;

   // register writes
   always_comb begin
      search_bytes_in  = search_bytes_ff;
      search_len_in    = search_len_ff;
      replace_bytes_in = replace_bytes_ff;
      replace_len_in   = replace_len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SEARCH_BYTES:  search_bytes_in  = csr_wdata;
            CSR_SEARCH_LEN:    search_len_in    = csr_wdata[LEN_W-1:0];
            CSR_REPLACE_BYTES: replace_bytes_in = csr_wdata;
            CSR_REPLACE_LEN:   replace_len_in   = csr_wdata[LEN_W-1:0];
            default:           search_len_in    = search_len_ff;
         endcase
      end
   end

   // clamp lengths
   always_comb begin
      if (search_len_ff == '0) begin
         slen_eff = LEN_W'(1);
      end else if (search_len_ff > LEN_W'(MAX_PATTERN)) begin
         slen_eff = LEN_W'(MAX_PATTERN);
      end else begin
         slen_eff = search_len_ff;
      end
      if (replace_len_ff > LEN_W'(MAX_REPLACEMENT)) begin
         rlen_eff = LEN_W'(MAX_REPLACEMENT);
      end else begin
         rlen_eff = replace_len_ff;
      end
   end

   // prefix compare of the window tail from each start offset
   always_comb begin
      for (int s = 0; s < MAX_PATTERN; s++) begin
         pre[s] = 1'b1;
         for (int j = 0; j < MAX_PATTERN - s; j++) begin
            if ((s + j) < int'(cnt_ff) &&
                win_ff[s + j] != search_bytes_ff[BYTE_W*j +: BYTE_W]) begin
               pre[s] = 1'b0;
            end
         end
         ok[s] = (s < int'(cnt_ff)) && ((int'(cnt_ff) - s) < int'(slen_eff)) && pre[s];
      end
   end

   // first offset that can still start a match
   always_comb begin
      start = cnt_ff;
      for (int s = MAX_PATTERN - 1; s >= 0; s--) begin
         if (ok[s]) start = CW'(s);
      end
      match    = (LEN_W'(cnt_ff) == slen_eff) && pre[0];
      win_emit = end_ff ? cnt_ff : start;
   end

   assign emit_last = marker_ff || (rem_ff == EW'(1));
   assign rep_shift = replace_bytes_ff >> {idx_ff, 3'b000};

   always_comb begin
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.emit_last  = emit_last;
      status.has_output = end_ff || (match ? (rlen_eff != '0) : (win_emit != '0));
   end

   // window, counters and output register
   always_comb begin
      win_in       = win_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      repl_in      = repl_ff;
      marker_in    = marker_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         // append the new byte behind the held bytes
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CW'(i) == cnt_ff) win_in[i] = req_data.in_byte;
         end
         cnt_in = cnt_ff + CW'(1);
         end_in = req_data.in_end;
      end

      if (cmd.eval) begin
         idx_in = '0;
         if (match) begin
            repl_in   = 1'b1;
            rem_in    = EW'(rlen_eff);
            cnt_in    = '0;
            marker_in = end_ff && (rlen_eff == '0);
         end else begin
            repl_in   = 1'b0;
            rem_in    = EW'(win_emit);
            marker_in = end_ff && (win_emit == '0);
         end
      end

      if (cmd.emit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.out_run_last   = emit_last;
         rsp_data_in.out_stream_end = emit_last && end_ff;
         if (marker_ff) begin
            rsp_data_in.out_byte    = '0;
            rsp_data_in.out_present = 1'b0;
         end else if (repl_ff) begin
            rsp_data_in.out_byte    = rep_shift[BYTE_W-1:0];
            rsp_data_in.out_present = 1'b1;
            idx_in                  = idx_ff + RW'(1);
            rem_in                  = rem_ff - EW'(1);
         end else begin
            // drop the front byte and advance the window
            rsp_data_in.out_byte    = win_ff[0];
            rsp_data_in.out_present = 1'b1;
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            cnt_in = cnt_ff - CW'(1);
            rem_in = rem_ff - EW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_bytes_ff  <= '0;
         search_len_ff    <= LEN_W'(1);
         replace_bytes_ff <= '0;
         replace_len_ff   <= '0;
         cnt_ff           <= '0;
         end_ff           <= 1'b0;
         repl_ff          <= 1'b0;
         marker_ff        <= 1'b0;
         rem_ff           <= '0;
         idx_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         search_bytes_ff  <= search_bytes_in;
         search_len_ff    <= search_len_in;
         replace_bytes_ff <= replace_bytes_in;
         replace_len_ff   <= replace_len_in;
         cnt_ff           <= cnt_in;
         end_ff           <= end_in;
         repl_ff          <= repl_in;
         marker_ff        <= marker_in;
         rem_ff           <= rem_in;
         idx_ff           <= idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // held bytes always leave room for the new byte
   a_room_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (cnt_ff < CW'(MAX_PATTERN)))
      else $error("window full when an item was taken");

   // a window byte is only emitted while the window holds one
   a_window_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !repl_ff && !marker_ff) |-> (cnt_ff != '0))
      else $error("emit from an empty window");

   // each emit lands in the output register with the right last flag
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && rsp_data_ff.out_run_last == $past(emit_last)))
      else $error("emitted result missing or last flag wrong");
`endif

endmodule
`default_nettype wire

// ----- rtl/stream_find_replace.sv -----
`default_nettype none
// Sequence: an accepted item is evaluated, then its results are loaded
// into the output register one at a time as that register frees up.
// Throughput: no new item is taken until the current one is done; unless
// stalled, the output register emits one byte per cycle from one window.
// Reset: synchronous; clears the held bytes count and sets the registers to
// their reset values (search length 1, all else 0).
// ----------------------------------------------------------------------------
// stream_find_replace: streaming search-and-replace over a byte stream
// Replaces every leftmost, non-overlapping pattern occurrence with the
// configured replacement and flushes held bytes at end of stream.
// ----------------------------------------------------------------------------
module stream_find_replace
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_payload_type       rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire csr_index_type    csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata
);

   sfr_cmd_type    cmd;
   sfr_status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfr_datapath #(
      .MAX_PATTERN     (MAX_PATTERN),
      .MAX_REPLACEMENT (MAX_REPLACEMENT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- tb/sv/stream_find_replace_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_tb: self-checking bench for the find-and-replace block
// Walks a short table of directed items and register writes, then runs
// random phases of text streams built from pattern pieces and noise. Every
// accepted input byte is run through a local model of the search window,
// and each output item is checked against the oldest awaited item.
// ----------------------------------------------------------------------------
module stream_find_replace_tb
   import sfr_pkg::*;
;

   localparam int            HALF_PERIOD   = 4;
   localparam int            RESET_CYCLES  = 5;
   localparam int            SETTLE_CYCLES = 4;
   localparam int            HOLD_OFF      = 300;
   localparam int            CYCLE_LIMIT   = 100000;
   localparam int            PHASES        = 10;
   localparam int            PHASE_ITEMS   = 19;
   localparam int            QUIET_PHASES  = 2;
   localparam csr_index_type CSR_UNUSED_LO = 3'd4;
   localparam csr_index_type CSR_UNUSED_HI = 3'd7;

   typedef enum logic {
      ROW_CSR,
      ROW_ITEM
   } row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      csr_index_type   idx;
      logic [63:0]     wdata;
      req_payload_type item;
      logic            fixed;
      rsp_payload_type want;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_payload_type  req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_payload_type  rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   csr_index_type    csr_index;
   logic [CFG_W-1:0] csr_wdata;

   // model copy of the registers and the held partial match
   logic [63:0] pat_bytes;
   logic [3:0]  pat_len_reg;
   logic [63:0] rep_bytes;
   logic [3:0]  rep_len_reg;
   logic [55:0] held_bits;
   int          held_n;

   rsp_payload_type step_out[$];
   rsp_payload_type awaited_text[$];
   stim_row_type    dir_table[$];

   int mismatch_count;
   int cycle_count;
   int rx_stall_left;
   bit hold_off_req;
   bit idle_on;

   stream_find_replace uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // free-running clock
   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stream_find_replace: mismatch");
         $finish;
      end
   end

   // pattern length as the block sees it: zero reads as one, saturate at 8
   function automatic int pattern_span();
      if (pat_len_reg == 4'd0)
         return 1;
      if (pat_len_reg > 4'd8)
         return 8;
      return int'(pat_len_reg);
   endfunction

   // do len bytes of w, from byte from on, equal the head of the pattern
   function automatic bit heads_pattern(input logic [63:0] w, input int from, input int len);
      logic [63:0] mask;
      logic [63:0] part;
      part = w >> (8 * from);
      if (len >= 8)
         mask = '1;
      else
         mask = (64'd1 << (8 * len)) - 64'd1;
      return ((part ^ pat_bytes) & mask) == 64'd0;
   endfunction

   function automatic void push_text(input logic [7:0] b);
      rsp_payload_type r;
      r = '0;
      r.out_byte = b;
      r.out_present = 1'b1;
      step_out.push_back(r);
   endfunction

   // work out the output items one input byte causes and advance the window
   function automatic void find_replace_byte(input req_payload_type it);
      logic [63:0]     win;
      int              n;
      int              start;
      int              slen;
      int              rlen;
      rsp_payload_type r;
      slen = pattern_span();
      rlen = (rep_len_reg > 4'd8) ? 8 : int'(rep_len_reg);
      step_out.delete();
      win = {8'h00, held_bits};
      n = held_n;
      win[8 * n +: 8] = it.in_byte;
      n++;
      start = 0;
      if (n == slen && heads_pattern(win, 0, n)) begin
         for (int i = 0; i < rlen; i++)
            push_text(rep_bytes[8 * i +: 8]);
         n = 0;
      end else begin
         // drop leading bytes until the rest is a short pattern head
         while (start < n && !((n - start) < slen && heads_pattern(win, start, n - start))) begin
            push_text(win[8 * start +: 8]);
            start++;
         end
      end
      if (it.in_end) begin
         // flush what is held; an empty stream end still gives a marker
         while (start < n) begin
            push_text(win[8 * start +: 8]);
            start++;
         end
         held_n = 0;
         if (step_out.size() == 0)
            step_out.push_back('0);
         r = step_out.pop_back();
         r.out_stream_end = 1'b1;
         step_out.push_back(r);
      end else begin
         held_n = n - start;
         held_bits = 56'(win >> (8 * start));
      end
      if (step_out.size() > 0) begin
         r = step_out.pop_back();
         r.out_run_last = 1'b1;
         step_out.push_back(r);
      end
   endfunction

   function automatic void flag_mismatch(input string why, input rsp_payload_type want,
                                         input rsp_payload_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("%0t %s: want byte %02h present %0b end %0b last %0b, ",
                $realtime, why, want.out_byte, want.out_present, want.out_stream_end,
                want.out_run_last);
         $display("got byte %02h present %0b end %0b last %0b",
                  got.out_byte, got.out_present, got.out_stream_end, got.out_run_last);
      end
   endfunction

   // check each accepted output item against the oldest awaited one
   always @(posedge clock) begin : check_out
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_text.size() == 0) begin
            flag_mismatch("unexpected item", '0, rsp_data);
         end else begin
            want = awaited_text.pop_front();
            if (rsp_data.out_byte !== want.out_byte
                || rsp_data.out_present !== want.out_present
                || rsp_data.out_stream_end !== want.out_stream_end
                || rsp_data.out_run_last !== want.out_run_last)
               flag_mismatch("wrong item", want, rsp_data);
         end
      end
   end

   // output side: random stall bursts and one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            rx_stall_left = HOLD_OFF - 1;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one byte, with an optional idle burst before it
   task automatic offer_byte(input logic [7:0] b, input logic last_of_stream,
                             input logic fixed, input rsp_payload_type fixed_out);
      req_payload_type it;
      int              gap;
      it.in_byte = b;
      it.in_end = last_of_stream;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      find_replace_byte(it);
      if (fixed)
         awaited_text.push_back(fixed_out);
      else
         foreach (step_out[i])
            awaited_text.push_back(step_out[i]);
   endtask

   // write a register once the block has drained
   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      @(negedge clock) req_valid <= 1'b0;
      while (awaited_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SEARCH_BYTES:  pat_bytes = val;
         CSR_SEARCH_LEN:    pat_len_reg = val[3:0];
         CSR_REPLACE_BYTES: rep_bytes = val;
         CSR_REPLACE_LEN:   rep_len_reg = val[3:0];
         default: ;
      endcase
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic stim_row_type reg_row(input csr_index_type i, input logic [63:0] v);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.idx = i;
      r.wdata = v;
      return r;
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] b, input logic e);
      stim_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.item.in_byte = b;
      r.item.in_end = e;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(input logic [7:0] b, input logic e,
                                              input rsp_payload_type w);
      stim_row_type r;
      r = byte_row(b, e);
      r.fixed = 1'b1;
      r.want = w;
      return r;
   endfunction

   initial begin
      stim_row_type row;
      logic [7:0]   chunk[$];
      logic [63:0]  word;
      int           sent;
      int           span;
      int           len;
      bit           ending;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SEARCH_BYTES;
      csr_wdata = '0;
      pat_bytes = '0;
      pat_len_reg = 4'd1;
      rep_bytes = '0;
      rep_len_reg = 4'd0;
      held_bits = '0;
      held_n = 0;
      mismatch_count = 0;
      cycle_count = 0;
      rx_stall_left = 0;
      hold_off_req = 1'b0;
      idle_on = 1'b1;

      // after reset: pattern is a single zero byte, replacement empty
      dir_table.push_back(fixed_row(8'h41, 1'b1, rsp_payload_type'{8'h41, 1'b1, 1'b1, 1'b1}));
      dir_table.push_back(fixed_row(8'h00, 1'b1, rsp_payload_type'{8'h00, 1'b0, 1'b1, 1'b1}));
      dir_table.push_back(fixed_row(8'hFF, 1'b0, rsp_payload_type'{8'hFF, 1'b1, 1'b0, 1'b1}));
      dir_table.push_back(byte_row(8'h00, 1'b0));
      // three-byte pattern, two-byte replacement: match, broken match, overlap, flush
      dir_table.push_back(reg_row(CSR_SEARCH_BYTES, 64'h0000_0000_0043_4241));
      dir_table.push_back(reg_row(CSR_SEARCH_LEN, 64'd3));
      dir_table.push_back(reg_row(CSR_REPLACE_BYTES, 64'h0000_0000_0000_5A59));
      dir_table.push_back(reg_row(CSR_REPLACE_LEN, 64'd2));
      dir_table.push_back(byte_row(8'h41, 1'b0));
      dir_table.push_back(byte_row(8'h42, 1'b0));
      dir_table.push_back(byte_row(8'h43, 1'b0));
      dir_table.push_back(byte_row(8'h41, 1'b0));
      dir_table.push_back(byte_row(8'h42, 1'b0));
      dir_table.push_back(byte_row(8'h58, 1'b0));
      dir_table.push_back(byte_row(8'h41, 1'b0));
      dir_table.push_back(byte_row(8'h41, 1'b0));
      dir_table.push_back(byte_row(8'h42, 1'b0));
      dir_table.push_back(byte_row(8'h43, 1'b0));
      dir_table.push_back(byte_row(8'h41, 1'b0));
      dir_table.push_back(byte_row(8'h42, 1'b1));
      // zero pattern length reads as one, replacement length saturates
      dir_table.push_back(reg_row(CSR_SEARCH_BYTES, '1));
      dir_table.push_back(reg_row(CSR_SEARCH_LEN, 64'd0));
      dir_table.push_back(reg_row(CSR_REPLACE_BYTES, '1));
      dir_table.push_back(reg_row(CSR_REPLACE_LEN, 64'd15));
      dir_table.push_back(byte_row(8'hFF, 1'b1));
      dir_table.push_back(byte_row(8'h00, 1'b0));
      // pattern length saturates; then lower it with bytes still held
      dir_table.push_back(reg_row(CSR_SEARCH_BYTES, 64'h4141_4141_4141_4141));
      dir_table.push_back(reg_row(CSR_SEARCH_LEN, 64'd15));
      for (int i = 0; i < 5; i++)
         dir_table.push_back(byte_row(8'h41, 1'b0));
      dir_table.push_back(reg_row(CSR_SEARCH_LEN, 64'd3));
      // unknown register index must leave everything alone
      dir_table.push_back(reg_row(CSR_UNUSED_HI, '1));
      dir_table.push_back(byte_row(8'h41, 1'b0));
      dir_table.push_back(byte_row(8'h41, 1'b1));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed table
      foreach (dir_table[i]) begin
         row = dir_table[i];
         if (row.kind == ROW_CSR)
            write_reg(row.idx, row.wdata);
         else
            offer_byte(row.item.in_byte, row.item.in_end, row.fixed, row.want);
      end

      // random phases: new settings, then streams of pattern pieces and noise
      for (int phase = 0; phase < PHASES; phase++) begin
         idle_on = (phase < PHASES - QUIET_PHASES);
         if ($urandom_range(0, 1) == 0) begin
            word = {$urandom, $urandom};
         end else begin
            // two-letter alphabet gives self-overlapping patterns
            for (int i = 0; i < 8; i++)
               word[8 * i +: 8] = 8'h61 + 8'($urandom_range(0, 1));
         end
         write_reg(CSR_SEARCH_BYTES, word);
         word = {$urandom, $urandom};
         word[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 8));
         write_reg(CSR_SEARCH_LEN, word);
         write_reg(CSR_REPLACE_BYTES, {$urandom, $urandom});
         word = {$urandom, $urandom};
         word[3:0] = 4'($urandom_range(0, 15));
         write_reg(CSR_REPLACE_LEN, word);
         if ($urandom_range(0, 2) == 0)
            write_reg(csr_index_type'($urandom_range(CSR_UNUSED_LO, CSR_UNUSED_HI)),
                      {$urandom, $urandom});
         if (phase == 2)
            hold_off_req = 1'b1;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            span = pattern_span();
            chunk.delete();
            case ($urandom_range(0, 3))
               0: begin
                  for (int i = 0; i < span; i++)
                     chunk.push_back(pat_bytes[8 * i +: 8]);
               end
               1: begin
                  len = $urandom_range(1, (span > 1) ? span - 1 : 1);
                  for (int i = 0; i < len; i++)
                     chunk.push_back(pat_bytes[8 * i +: 8]);
               end
               2: begin
                  len = $urandom_range(1, 4);
                  for (int i = 0; i < len; i++)
                     chunk.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  len = $urandom_range(1, 4);
                  for (int i = 0; i < len; i++)
                     chunk.push_back(pat_bytes[8 * $urandom_range(0, span - 1) +: 8]);
               end
            endcase
            ending = ($urandom_range(0, 2) == 0);
            foreach (chunk[i]) begin
               offer_byte(chunk[i], ending && (i == chunk.size() - 1), 1'b0, '0);
               sent++;
            end
         end
      end

      // drain and let the block settle
      @(negedge clock) req_valid <= 1'b0;
      while (awaited_text.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatch_count == 0 && awaited_text.size() == 0)
         $display("stream_find_replace: match");
      else
         $display("stream_find_replace: mismatch");
      $finish;
   end

endmodule

// ----- stream_find_replace.f -----
rtl/sfr_pkg.sv
rtl/sfr_ctrl.sv
rtl/sfr_datapath.sv
rtl/stream_find_replace.sv
tb/sv/stream_find_replace_tb.sv
